@@ design/pct_pkg.sv @@
// pct_pkg: shared widths, constants, codes and helper functions for the
// timed PID controller. No dependencies; used by every design file.
`default_nettype none

package pct_pkg;

  // field and datapath widths
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned MUL_A_W   = 64;
  localparam int unsigned MUL_B_W   = 32;
  localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
  localparam int unsigned RND_SHIFT = 15;
  localparam int unsigned NUM_W     = PROD_W - RND_SHIFT;
  localparam int unsigned QUO_W     = 35;
  localparam int unsigned MAG_W     = 49;
  localparam int unsigned SUM_W     = 37;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_B_W + 1);
  localparam int unsigned DIV_CNT_W = $clog2(QUO_W + 1);

  // constants
  localparam logic [DATA_W-1:0] USEC_PER_SEC = 32'd1000000;
  localparam logic [DATA_W-1:0] POS_MAX      = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] NEG_MAX      = 32'h8000_0000;

  // command codes carried on in_tuser
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_RESET  = 1'b1;

  // configuration register indexes
  localparam int unsigned REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_TARGET     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_P     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_I     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CLAMP_LOW  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CLAMP_HIGH = 3'd5;

  // status of an iterative arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } pct_sts_t;

  // magnitude of a 32-bit signed value (the most negative value gives 2^31)
  function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] x);
    logic [DATA_W-1:0] neg;
    neg = -x;
    return x[DATA_W-1] ? neg : x;
  endfunction

  // magnitude of a 33-bit signed difference, always below 2^32
  function automatic logic [DATA_W-1:0] mag33(input logic [DATA_W:0] x);
    logic [DATA_W:0] neg;
    neg = -x;
    return x[DATA_W] ? neg[DATA_W-1:0] : x[DATA_W-1:0];
  endfunction

  // apply a sign to a magnitude and saturate to 32 bits
  function automatic logic [DATA_W-1:0] sat_mag(input logic neg,
                                                input logic [MAG_W-1:0] mag);
    logic [DATA_W-1:0] res;
    if (!neg) begin
      if (mag > MAG_W'(POS_MAX)) res = POS_MAX;
      else res = mag[DATA_W-1:0];
    end else begin
      if (mag > MAG_W'(NEG_MAX)) res = NEG_MAX;
      else res = -mag[DATA_W-1:0];
    end
    return res;
  endfunction

  // limit rule: below low gives low, otherwise above high gives high
  function automatic logic [DATA_W-1:0] clamp_lim(input logic signed [SUM_W-1:0] v,
                                                  input logic signed [DATA_W-1:0] lo,
                                                  input logic signed [DATA_W-1:0] hi);
    logic signed [SUM_W-1:0] lo_x;
    logic signed [SUM_W-1:0] hi_x;
    logic [DATA_W-1:0] res;
    lo_x = SUM_W'(lo);
    hi_x = SUM_W'(hi);
    priority if (v < lo_x) res = lo;
    else if (v > hi_x) res = hi;
    else res = v[DATA_W-1:0];
    return res;
  endfunction

endpackage

`default_nettype wire

@@ design/pct_mul.sv @@
// pct_mul: shift-add multiplier, one bit of the second operand per cycle.
// Depends on pct_pkg for widths and the unit status struct.
`default_nettype none

module pct_mul (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          go,
  input  wire logic [pct_pkg::MUL_A_W-1:0]   mul_a,
  input  wire logic [pct_pkg::MUL_B_W-1:0]   mul_b,
  output logic      [pct_pkg::PROD_W-1:0]    prod,
  output pct_pkg::pct_sts_t                  sts
);

  logic [pct_pkg::MUL_A_W-1:0]   a_r, a_nxt;
  logic [pct_pkg::PROD_W-1:0]    acc_r, acc_nxt;
  logic [pct_pkg::MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [pct_pkg::MUL_A_W:0]     sum_w;

  // conditional add into the upper half, then shift right one bit
  assign sum_w = {1'b0, acc_r[pct_pkg::PROD_W-1:pct_pkg::MUL_B_W]} +
                 (acc_r[0] ? {1'b0, a_r} : '0);

  always_comb begin
    a_nxt    = a_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    priority if (go) begin
      a_nxt    = mul_a;
      acc_nxt  = {{pct_pkg::MUL_A_W{1'b0}}, mul_b};
      cnt_nxt  = pct_pkg::MUL_CNT_W'(pct_pkg::MUL_B_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = {sum_w, acc_r[pct_pkg::MUL_B_W-1:1]};
      cnt_nxt = cnt_r - pct_pkg::MUL_CNT_W'(1);
      if (cnt_r == pct_pkg::MUL_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    a_r   <= a_nxt;
    acc_r <= acc_nxt;
  end

  assign prod     = acc_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

`default_nettype wire

@@ design/pct_div.sv @@
// pct_div: restoring divider, one quotient bit per cycle, saturating quotient.
// Depends on pct_pkg for widths and the unit status struct.
`default_nettype none

module pct_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          go,
  input  wire logic [pct_pkg::NUM_W-1:0]     num,
  input  wire logic [pct_pkg::DATA_W-1:0]    den,
  output logic      [pct_pkg::QUO_W-1:0]     quo,
  output pct_pkg::pct_sts_t                  sts
);

  localparam int unsigned HI_W = pct_pkg::NUM_W - pct_pkg::QUO_W;

  logic [pct_pkg::DATA_W-1:0]    rem_r, rem_nxt;
  logic [pct_pkg::DATA_W-1:0]    den_r, den_nxt;
  logic [pct_pkg::QUO_W-1:0]     q_r, q_nxt;
  logic                          ovf_r, ovf_nxt;
  logic [pct_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [pct_pkg::DATA_W:0]      trial_w;
  logic [pct_pkg::DATA_W:0]      diff_w;
  logic                          ge_w;

  // trial subtract of the divisor from the shifted partial remainder
  assign trial_w = {rem_r, q_r[pct_pkg::QUO_W-1]};
  assign diff_w  = trial_w - {1'b0, den_r};
  assign ge_w    = (trial_w >= {1'b0, den_r});

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    priority if (go) begin
      // quotient too wide for the register, or divisor zero: saturate
      ovf_nxt  = (num[pct_pkg::NUM_W-1:pct_pkg::QUO_W] >= HI_W'(den));
      rem_nxt  = num[pct_pkg::QUO_W+pct_pkg::DATA_W-1:pct_pkg::QUO_W];
      q_nxt    = num[pct_pkg::QUO_W-1:0];
      den_nxt  = den;
      cnt_nxt  = pct_pkg::DIV_CNT_W'(pct_pkg::QUO_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge_w ? diff_w[pct_pkg::DATA_W-1:0] : trial_w[pct_pkg::DATA_W-1:0];
      q_nxt   = {q_r[pct_pkg::QUO_W-2:0], ge_w};
      cnt_nxt = cnt_r - pct_pkg::DIV_CNT_W'(1);
      if (cnt_r == pct_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
    ovf_r <= ovf_nxt;
  end

  assign quo      = ovf_r ? '1 : q_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

`default_nettype wire

@@ design/pid_controller_timed.sv @@
// pid_controller_timed: timed PID controller top level, sequencer and state.
// Depends on pct_pkg, pct_mul and pct_div.
//
// channel   dir  handshake            payload
// in_*      in   in_tvalid/in_tready  tdata {timestamp, measurement}, tuser cmd
// out_*     out  out_tvalid/out_tready tdata {d_term, i_term, p_term, drive}
// cfg_*     in   cfg_we               cfg_index, cfg_data
//
// An update item runs five passes of the shift-add multiplier and up to two
// passes of the restoring divider, one after another, between acceptance and
// its result in the output register; the second divide is skipped when dt is 0.
// Items are processed one at a time.
// The output register holds a result while the next item is accepted.
// Reset is synchronous and active low; it clears controller state and opens the limits to the full range.
`default_nettype none

module pid_controller_timed (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input items
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [63:0]  in_tdata,   // [31:0] measurement, [63:32] timestamp
  input  wire logic         in_tuser,   // [0] cmd
  // result items
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic      [127:0] out_tdata,  // [31:0] drive, [63:32] p_term,
                                        // [95:64] i_term, [127:96] d_term
  // configuration writes
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_MUL_P,
    S_MUL_I1,
    S_MUL_I2,
    S_DIV_I,
    S_MUL_D1,
    S_MUL_D2,
    S_DIV_D,
    S_INTEG,
    S_DRIVE,
    S_OUT
  } state_t;

  localparam int unsigned DW = pct_pkg::DATA_W;
  localparam int unsigned QW = pct_pkg::QUO_W;

  // configuration registers
  logic signed [DW-1:0] tgt_r, kp_r, ki_r, kd_r, clo_r, chi_r;

  // sequencer and datapath registers
  state_t               state_r, state_nxt;
  logic                 go_r, go_nxt;
  logic                 cmd_r, cmd_nxt;
  logic signed [DW-1:0] meas_r, meas_nxt;
  logic [DW-1:0]        ts_r, ts_nxt;
  logic signed [DW-1:0] prev_meas_r, prev_meas_nxt;
  logic signed [DW-1:0] integ_r, integ_nxt;
  logic [DW-1:0]        prev_time_r, prev_time_nxt;
  logic                 err_neg_r, err_neg_nxt;
  logic [DW-1:0]        err_mag_r, err_mag_nxt;
  logic                 dm_neg_r, dm_neg_nxt;
  logic [DW-1:0]        dm_mag_r, dm_mag_nxt;
  logic [DW-1:0]        dt_r, dt_nxt;
  logic signed [DW-1:0] p_r, p_nxt;
  logic signed [DW-1:0] d_r, d_nxt;
  logic signed [QW:0]   step_r, step_nxt;
  logic signed [DW-1:0] drive_r, drive_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [127:0]         out_data_r, out_data_nxt;

  // arithmetic unit connections
  logic [pct_pkg::MUL_A_W-1:0] mul_a;
  logic [pct_pkg::MUL_B_W-1:0] mul_b;
  logic [pct_pkg::PROD_W-1:0]  mul_prod;
  pct_pkg::pct_sts_t           mul_sts;
  logic                        mul_go;
  logic [DW-1:0]               div_den;
  logic [QW-1:0]               div_quo;
  pct_pkg::pct_sts_t           div_sts;
  logic                        div_go;

  // combinational helpers
  logic [DW:0]                  err_w;
  logic [DW:0]                  dm_w;
  logic [pct_pkg::MAG_W:0]      p_inc_w;
  logic [QW:0]                  q_inc_w;
  logic [QW-1:0]                q_mag_w;
  logic signed [pct_pkg::SUM_W-1:0] integ_sum_w;
  logic signed [pct_pkg::SUM_W-1:0] drive_sum_w;

  // configuration write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r <= '0;
      kp_r  <= '0;
      ki_r  <= '0;
      kd_r  <= '0;
      clo_r <= pct_pkg::NEG_MAX;
      chi_r <= pct_pkg::POS_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pct_pkg::REG_TARGET:     tgt_r <= cfg_data;
        pct_pkg::REG_GAIN_P:     kp_r  <= cfg_data;
        pct_pkg::REG_GAIN_I:     ki_r  <= cfg_data;
        pct_pkg::REG_GAIN_D:     kd_r  <= cfg_data;
        pct_pkg::REG_CLAMP_LOW:  clo_r <= cfg_data;
        pct_pkg::REG_CLAMP_HIGH: chi_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // error, measurement change, rounding and sums
  assign err_w   = {tgt_r[DW-1], tgt_r} - {meas_r[DW-1], meas_r};
  assign dm_w    = {meas_r[DW-1], meas_r} - {prev_meas_r[DW-1], prev_meas_r};
  // round half up on the magnitude: (floor(x / 2^15) + 1) / 2
  assign p_inc_w = {1'b0, mul_prod[pct_pkg::MAG_W+pct_pkg::RND_SHIFT-1:pct_pkg::RND_SHIFT]}
                   + (pct_pkg::MAG_W+1)'(1);
  assign q_inc_w = {1'b0, div_quo} + (QW+1)'(1);
  assign q_mag_w = q_inc_w[QW:1];
  assign integ_sum_w = pct_pkg::SUM_W'(integ_r) + pct_pkg::SUM_W'(step_r);
  assign drive_sum_w = pct_pkg::SUM_W'(p_r) + pct_pkg::SUM_W'(integ_r) +
                       pct_pkg::SUM_W'(d_r);

  // operand selection for the shared units
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MUL_P: begin
        mul_a = pct_pkg::MUL_A_W'(err_mag_r);
        mul_b = pct_pkg::mag32(kp_r);
      end
      S_MUL_I1: begin
        mul_a = pct_pkg::MUL_A_W'(err_mag_r);
        mul_b = pct_pkg::mag32(ki_r);
      end
      S_MUL_I2: begin
        mul_a = mul_prod[pct_pkg::MUL_A_W-1:0];
        mul_b = dt_r;
      end
      S_MUL_D1: begin
        mul_a = pct_pkg::MUL_A_W'(dm_mag_r);
        mul_b = pct_pkg::mag32(kd_r);
      end
      S_MUL_D2: begin
        mul_a = mul_prod[pct_pkg::MUL_A_W-1:0];
        mul_b = pct_pkg::USEC_PER_SEC;
      end
      default: ;
    endcase
  end

  assign mul_go  = go_r && (state_r == S_MUL_P || state_r == S_MUL_I1 ||
                            state_r == S_MUL_I2 || state_r == S_MUL_D1 ||
                            state_r == S_MUL_D2);
  assign div_go  = go_r && (state_r == S_DIV_I || state_r == S_DIV_D);
  assign div_den = (state_r == S_DIV_D) ? dt_r : pct_pkg::USEC_PER_SEC;

  pct_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mul_go),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (mul_prod),
    .sts   (mul_sts)
  );

  pct_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .num   (mul_prod[pct_pkg::PROD_W-1:pct_pkg::RND_SHIFT]),
    .den   (div_den),
    .quo   (div_quo),
    .sts   (div_sts)
  );

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    go_nxt        = 1'b0;
    cmd_nxt       = cmd_r;
    meas_nxt      = meas_r;
    ts_nxt        = ts_r;
    prev_meas_nxt = prev_meas_r;
    integ_nxt     = integ_r;
    prev_time_nxt = prev_time_r;
    err_neg_nxt   = err_neg_r;
    err_mag_nxt   = err_mag_r;
    dm_neg_nxt    = dm_neg_r;
    dm_mag_nxt    = dm_mag_r;
    dt_nxt        = dt_r;
    p_nxt         = p_r;
    d_nxt         = d_r;
    step_nxt      = step_r;
    drive_nxt     = drive_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = in_tuser;
          meas_nxt  = in_tdata[31:0];
          ts_nxt    = in_tdata[63:32];
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if (cmd_r == pct_pkg::CMD_RESET) begin
          prev_meas_nxt = '0;
          integ_nxt     = '0;
          prev_time_nxt = ts_r;
          p_nxt         = '0;
          d_nxt         = '0;
          drive_nxt     = '0;
          state_nxt     = S_OUT;
        end else begin
          err_neg_nxt   = err_w[DW];
          err_mag_nxt   = pct_pkg::mag33(err_w);
          dm_neg_nxt    = dm_w[DW];
          dm_mag_nxt    = pct_pkg::mag33(dm_w);
          dt_nxt        = ts_r - prev_time_r;
          prev_time_nxt = ts_r;
          prev_meas_nxt = meas_r;
          state_nxt     = S_MUL_P;
          go_nxt        = 1'b1;
        end
      end
      S_MUL_P: begin
        if (mul_sts.done) begin
          p_nxt     = pct_pkg::sat_mag(err_neg_r ^ kp_r[DW-1],
                                       p_inc_w[pct_pkg::MAG_W:1]);
          state_nxt = S_MUL_I1;
          go_nxt    = 1'b1;
        end
      end
      S_MUL_I1: begin
        if (mul_sts.done) begin
          state_nxt = S_MUL_I2;
          go_nxt    = 1'b1;
        end
      end
      S_MUL_I2: begin
        if (mul_sts.done) begin
          state_nxt = S_DIV_I;
          go_nxt    = 1'b1;
        end
      end
      S_DIV_I: begin
        // integral step, saturated well beyond the 32-bit limits
        if (div_sts.done) begin
          step_nxt  = (err_neg_r ^ ki_r[DW-1]) ? -{1'b0, q_mag_w} : {1'b0, q_mag_w};
          state_nxt = S_MUL_D1;
          go_nxt    = 1'b1;
        end
      end
      S_MUL_D1: begin
        if (mul_sts.done) begin
          state_nxt = S_MUL_D2;
          go_nxt    = 1'b1;
        end
      end
      S_MUL_D2: begin
        if (mul_sts.done) begin
          if (dt_r == '0) begin
            d_nxt     = '0;
            state_nxt = S_INTEG;
          end else begin
            state_nxt = S_DIV_D;
            go_nxt    = 1'b1;
          end
        end
      end
      S_DIV_D: begin
        // derivative acts against the measurement change
        if (div_sts.done) begin
          d_nxt     = pct_pkg::sat_mag(~(dm_neg_r ^ kd_r[DW-1]),
                                       pct_pkg::MAG_W'(q_mag_w));
          state_nxt = S_INTEG;
        end
      end
      S_INTEG: begin
        integ_nxt = pct_pkg::clamp_lim(integ_sum_w, clo_r, chi_r);
        state_nxt = S_DRIVE;
      end
      S_DRIVE: begin
        drive_nxt = pct_pkg::clamp_lim(drive_sum_w, clo_r, chi_r);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {d_r, integ_r, p_r, drive_r};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer state, controller state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      prev_meas_r <= '0;
      integ_r     <= '0;
      prev_time_r <= '0;
    end else begin
      state_r     <= state_nxt;
      go_r        <= go_nxt;
      out_valid_r <= out_valid_nxt;
      prev_meas_r <= prev_meas_nxt;
      integ_r     <= integ_nxt;
      prev_time_r <= prev_time_nxt;
    end
    cmd_r      <= cmd_nxt;
    meas_r     <= meas_nxt;
    ts_r       <= ts_nxt;
    err_neg_r  <= err_neg_nxt;
    err_mag_r  <= err_mag_nxt;
    dm_neg_r   <= dm_neg_nxt;
    dm_mag_r   <= dm_mag_nxt;
    dt_r       <= dt_nxt;
    p_r        <= p_nxt;
    d_r        <= d_nxt;
    step_r     <= step_nxt;
    drive_r    <= drive_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // integral lands inside ordered limits once updated
  a_integ_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRIVE && $past(clo_r) <= $past(chi_r)) |->
      (integ_r >= $past(clo_r) && integ_r <= $past(chi_r)))
    else $error("integral outside clamp range");

  // derivative term is zero when no time has passed
  a_d_zero_dt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INTEG && dt_r == '0) |-> (d_r == '0))
    else $error("derivative term nonzero with zero dt");

  // multiplier finishes only while the sequencer waits on it
  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_sts.done |-> (state_r == S_MUL_P || state_r == S_MUL_I1 ||
                      state_r == S_MUL_I2 || state_r == S_MUL_D1 ||
                      state_r == S_MUL_D2))
    else $error("multiplier done outside a multiply step");

  // no unit is restarted while it still iterates
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (!mul_go || !mul_sts.busy) && (!div_go || !div_sts.busy))
    else $error("arithmetic unit started while busy");

endmodule

`default_nettype wire

@@ test/pid_controller_timed_test.sv @@
// pid_controller_timed_test: self-checking bench for the timed PID controller.
// Depends on pct_pkg and pid_controller_timed; a scoreboard class predicts
// each result exactly and checks it, while plain tasks drive items and writes.

module pid_controller_timed_test;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [31:0] drive;
    logic [31:0] p_term;
    logic [31:0] i_term;
    logic [31:0] d_term;
  } ctrl_out_t;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 180;
  localparam int unsigned TAIL_CYCLES = 300;

  // exact PID prediction plus the queue of results still owed by the block
  class pid_reckoner;
    logic signed [31:0] target, gain_p, gain_i, gain_d, lim_lo, lim_hi;
    logic signed [31:0] last_meas, integ;
    logic [31:0] last_ts;
    ctrl_out_t owed[$];
    int unsigned mismatches;

    function new();
      target = 0;
      gain_p = 0;
      gain_i = 0;
      gain_d = 0;
      lim_lo = 32'sh8000_0000;
      lim_hi = 32'sh7fff_ffff;
      last_meas = 0;
      integ = 0;
      last_ts = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        pct_pkg::REG_TARGET:     target = val;
        pct_pkg::REG_GAIN_P:     gain_p = val;
        pct_pkg::REG_GAIN_I:     gain_i = val;
        pct_pkg::REG_GAIN_D:     gain_d = val;
        pct_pkg::REG_CLAMP_LOW:  lim_lo = val;
        pct_pkg::REG_CLAMP_HIGH: lim_hi = val;
        default: ;
      endcase
    endfunction

    function wide_t widen(logic signed [31:0] x);
      return x;
    endfunction

    // quotient rounded to nearest, ties away from zero
    function wide_t round_quot(wide_t num, wide_t den);
      wide_t mag;
      wide_t q;
      mag = (num < 0) ? -num : num;
      q = (2 * mag + den) / (2 * den);
      return (num < 0) ? -q : q;
    endfunction

    function logic signed [31:0] sat_word(wide_t v);
      if (v > 128'sd2147483647) return 32'sh7fff_ffff;
      if (v < -128'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    // low limit wins first, so crossed limits behave as the block defines
    function logic signed [31:0] to_window(wide_t v);
      if (v < widen(lim_lo)) return lim_lo;
      if (v > widen(lim_hi)) return lim_hi;
      return v[31:0];
    endfunction

    function void note_item(logic cmd, logic [31:0] meas, logic [31:0] ts);
      ctrl_out_t res;
      logic [31:0] dt;
      wide_t err;
      wide_t meas_w;
      wide_t dt_w;
      logic signed [31:0] p;
      logic signed [31:0] d;
      if (cmd == pct_pkg::CMD_RESET) begin
        last_meas = 0;
        integ = 0;
        last_ts = ts;
        res.drive = '0;
        res.p_term = '0;
        res.i_term = '0;
        res.d_term = '0;
        owed.push_back(res);
        return;
      end
      dt = ts - last_ts;
      last_ts = ts;
      meas_w = $signed(meas);
      dt_w = dt;
      err = widen(target) - meas_w;
      p = sat_word(round_quot(err * widen(gain_p), 128'sd65536));
      integ = to_window(widen(integ)
                        + round_quot(err * widen(gain_i) * dt_w, 128'sd65536000000));
      // derivative on measurement, dropped when no time has passed
      if (dt == 0) d = 0;
      else d = sat_word(-round_quot((meas_w - widen(last_meas)) * widen(gain_d)
                                    * 128'sd1000000, dt_w * 128'sd65536));
      last_meas = meas;
      res.drive = to_window(widen(p) + widen(integ) + widen(d));
      res.p_term = p;
      res.i_term = integ;
      res.d_term = d;
      owed.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      end
    endfunction

    function void check_result(logic [127:0] data);
      ctrl_out_t want;
      if (owed.size() == 0) begin
        mismatches++;
        $error("result with no item pending: %h", data);
        return;
      end
      want = owed.pop_front();
      compare_field("drive", want.drive, data[31:0]);
      compare_field("p_term", want.p_term, data[63:32]);
      compare_field("i_term", want.i_term, data[95:64]);
      compare_field("d_term", want.d_term, data[127:96]);
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [63:0]  in_tdata = '0;   // [31:0] measurement, [63:32] timestamp
  logic         in_tuser = 1'b0; // [0] cmd
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;       // [31:0] drive, [63:32] p_term,
                                 // [95:64] i_term, [127:96] d_term
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  pid_reckoner ctrl_calc = new();

  bit          in_idle = 1'b1;
  int unsigned in_run = 0;
  bit          out_idle = 1'b1;
  int unsigned out_run = 0;
  logic [31:0] ts_now = '0;
  logic [31:0] cur_target = '0;
  int unsigned cycle_count = 0;

  pid_controller_timed u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // result side: random stalls in runs, with stretches of none
  initial begin
    int unsigned stall;
    wait (rst_n === 1'b1);
    forever begin
      if (out_run == 0) begin
        out_run = $urandom_range(10, 60);
        out_idle = ($urandom_range(0, 3) != 0);
      end
      out_run--;
      stall = out_idle ? $urandom_range(0, 19) : 0;
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      ctrl_calc.check_result(out_tdata);
    end
  end

  // send one item, with a random gap ahead of it
  task automatic push_item(logic cmd, logic [31:0] meas, logic [31:0] ts);
    int unsigned gap;
    if (in_run == 0) begin
      in_run = $urandom_range(10, 60);
      in_idle = ($urandom_range(0, 3) != 0);
    end
    in_run--;
    gap = in_idle ? $urandom_range(0, 19) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {ts, meas};
    in_tuser <= cmd;
    do @(posedge clk); while (!in_tready);
    ctrl_calc.note_item(cmd, meas, ts);
  endtask

  task automatic update_at(logic [31:0] meas, logic [31:0] ts);
    ts_now = ts;
    push_item(pct_pkg::CMD_UPDATE, meas, ts);
  endtask

  task automatic reset_at(logic [31:0] ts);
    ts_now = ts;
    push_item(pct_pkg::CMD_RESET, $urandom(), ts);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    ctrl_calc.set_reg(idx, val);
  endtask

  // new settings only once the block has delivered everything
  task automatic apply_settings(logic [31:0] tgt, logic [31:0] gp, logic [31:0] gi,
                                logic [31:0] gd, logic [31:0] lo, logic [31:0] hi);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (ctrl_calc.pending() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    write_reg(pct_pkg::REG_TARGET, tgt);
    write_reg(pct_pkg::REG_GAIN_P, gp);
    write_reg(pct_pkg::REG_GAIN_I, gi);
    write_reg(pct_pkg::REG_GAIN_D, gd);
    write_reg(pct_pkg::REG_CLAMP_LOW, lo);
    write_reg(pct_pkg::REG_CLAMP_HIGH, hi);
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_target = tgt;
  endtask

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(0, 8))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom();
      8: return '0;
      default: return $urandom_range(0, 1 << 19) - (1 << 18);
    endcase
  endfunction

  // random settings: mostly moderate, sometimes full range, crossed or open limits
  task automatic random_settings();
    logic [31:0] tgt;
    logic [31:0] lo;
    logic [31:0] hi;
    int unsigned pick;
    tgt = ($urandom_range(0, 4) == 0) ? $urandom()
                                      : $urandom_range(0, 1 << 21) - (1 << 20);
    pick = $urandom_range(0, 7);
    if (pick < 2) begin
      lo = 32'h8000_0000;
      hi = 32'h7fff_ffff;
    end else if (pick == 2) begin
      lo = $urandom_range(0, 1 << 20);
      hi = 0 - $urandom_range(1, 1 << 20);
    end else begin
      lo = 0 - $urandom_range(0, 1 << 24);
      hi = $urandom_range(0, 1 << 24);
    end
    apply_settings(tgt, rand_gain(), rand_gain(), rand_gain(), lo, hi);
  endtask

  // mostly a steady loop near the setpoint, with jumps, resets and odd values
  task automatic random_item();
    logic [31:0] meas;
    logic [31:0] step;
    int unsigned pick;
    if ($urandom_range(0, 99) < 4) begin
      reset_at($urandom());
      return;
    end
    pick = $urandom_range(0, 99);
    if (pick < 6) step = 0;
    else if (pick < 70) step = $urandom_range(1, 2000);
    else if (pick < 92) step = $urandom_range(2001, 1000000);
    else step = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 65) meas = cur_target + ($urandom_range(0, 1 << 20) - (1 << 19));
    else if (pick < 88) meas = $urandom();
    else if (pick < 94) meas = 32'h7fff_ffff;
    else meas = 32'h8000_0000;
    update_at(meas, ts_now + step);
  endtask

  // stimulus
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // moderate gains, narrow limits: first update, zero dt, extremes, wrap
    apply_settings(32'h0001_0000, 32'h0001_8000, 32'h0002_0000, 32'h0000_4000,
                   32'hfff0_0000, 32'h0010_0000);
    update_at(32'h0000_0000, 32'd1000);
    update_at(32'h7fff_ffff, 32'd1000);
    update_at(32'h8000_0000, 32'd2000);
    update_at(32'h0000_8000, 32'hffff_ff00);
    update_at(32'h0000_1234, 32'h0000_0100);
    reset_at(32'hffff_ffff);
    update_at(32'h0000_0000, 32'h0000_000f);
    update_at(32'hffff_ffff, 32'h0000_000f);

    // extreme gains and setpoint, full limits
    apply_settings(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                   32'h8000_0000, 32'h7fff_ffff);
    reset_at(32'h0000_0000);
    update_at(32'h7fff_ffff, 32'h0000_0001);
    update_at(32'h8000_0000, 32'h0000_0001);
    update_at(32'h7fff_ffff, 32'h0000_0000);

    // crossed limits
    apply_settings(32'h0000_0000, 32'h0001_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h0001_0000, 32'hffff_0000);
    update_at(32'h0002_0000, ts_now + 500);
    update_at(32'hfffe_0000, ts_now + 500);
    update_at(32'h0000_0000, ts_now + 500);
    update_at(32'h0000_8000, ts_now + 1);

    // random phases
    for (int ph = 0; ph < PHASES; ph++) begin
      random_settings();
      for (int n = 0; n < PHASE_ITEMS; n++) random_item();
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (ctrl_calc.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (ctrl_calc.mismatches == 0 && ctrl_calc.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
